/* rtl/core/knn_pkg.sv */
// shared constants, codes and controller/datapath interface types for the knn classifier
`timescale 1ns / 1ps
package knn_pkg;

    localparam int MAX_TRAIN_ROWS_DEF = 256;
    localparam int FEATURE_COUNT_DEF  = 784;
    localparam int CLASS_COUNT_DEF    = 10;

    localparam int LABEL_W = 4;
    localparam int FEAT_W  = 8;
    localparam int OP_W    = 2;
    localparam int K_W     = 8;

    localparam logic [K_W-1:0] K_RESET = 8'd5;

    typedef enum logic [OP_W-1:0] {
        OP_TRAIN  = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_UNUSED = 2'd3
    } knn_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIST_INIT,
        ST_DIST,
        ST_SEL_INIT,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_PICK,
        ST_ARGMAX,
        ST_OUT
    } knn_state_t;

    typedef struct packed {
        logic take;
        logic fill_step;
        logic dist_init;
        logic dist_run;
        logic pick_init;
        logic scan_init;
        logic scan_run;
        logic pick;
        logic argmax_run;
        logic out_load;
    } knn_cmd_t;

    typedef struct packed {
        logic fill_req;
        logic query_end;
        logic fill_last;
        logic fill_query;
        logic dist_done;
        logic picks_zero;
        logic scan_done;
        logic pick_final;
        logic argmax_done;
        logic out_free;
    } knn_status_t;

endpackage

/* rtl/core/knn_ctrl.sv */
// sequencing state machine for the knn classifier
`timescale 1ns / 1ps
module knn_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  knn_pkg::knn_status_t  status,
    output knn_pkg::knn_cmd_t     cmd
);
    import knn_pkg::*;

    knn_state_t state_reg;
    knn_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (status.fill_req) begin
                        state_next = ST_FILL;
                    end else if (status.query_end) begin
                        state_next = ST_DIST_INIT;
                    end
                end
            end
            ST_FILL: begin
                if (status.fill_last) begin
                    state_next = status.fill_query ? ST_DIST_INIT : ST_IDLE;
                end
            end
            ST_DIST_INIT: state_next = ST_DIST;
            ST_DIST: begin
                if (status.dist_done) begin
                    state_next = ST_SEL_INIT;
                end
            end
            ST_SEL_INIT: state_next = status.picks_zero ? ST_ARGMAX : ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN;
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: state_next = status.pick_final ? ST_ARGMAX : ST_SCAN_INIT;
            ST_ARGMAX: begin
                if (status.argmax_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_FILL:      cmd.fill_step  = 1'b1;
            ST_DIST_INIT: cmd.dist_init  = 1'b1;
            ST_DIST:      cmd.dist_run   = 1'b1;
            ST_SEL_INIT:  cmd.pick_init  = 1'b1;
            ST_SCAN_INIT: cmd.scan_init  = 1'b1;
            ST_SCAN:      cmd.scan_run   = 1'b1;
            ST_PICK:      cmd.pick       = 1'b1;
            ST_ARGMAX:    cmd.argmax_run = 1'b1;
            ST_OUT:       cmd.out_load   = status.out_free;
            default:      cmd            = '0;
        endcase
    end

    // a request is only taken while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> state_reg == ST_IDLE)
        else $error("request taken outside idle");
    // a result is loaded only on leaving the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("result load without return to idle");
    // each pick scan is preceded by its init
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && !$past(state_reg == ST_SCAN) |-> $past(cmd.scan_init))
        else $error("scan entered without init");

endmodule

/* rtl/core/knn_dpath.sv */
// stores, distance pipeline, neighbor selection and vote for the knn classifier
`timescale 1ns / 1ps
module knn_dpath #(
    parameter int MAX_TRAIN_ROWS = knn_pkg::MAX_TRAIN_ROWS_DEF,
    parameter int FEATURE_COUNT  = knn_pkg::FEATURE_COUNT_DEF,
    parameter int CLASS_COUNT    = knn_pkg::CLASS_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  knn_pkg::knn_cmd_t             cmd,
    output knn_pkg::knn_status_t          status,
    input  logic [knn_pkg::OP_W-1:0]      in_op,
    input  logic [knn_pkg::FEAT_W-1:0]    in_feature,
    input  logic [knn_pkg::LABEL_W-1:0]   in_label,
    input  logic                          in_last,
    input  logic [knn_pkg::K_W-1:0]       k_value,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [knn_pkg::LABEL_W-1:0]   out_class,
    output logic                          out_overflow
);
    import knn_pkg::*;

    localparam int RcW  = $clog2(MAX_TRAIN_ROWS + 1);
    localparam int RiW  = (MAX_TRAIN_ROWS > 1) ? $clog2(MAX_TRAIN_ROWS) : 1;
    localparam int PosW = $clog2(FEATURE_COUNT + 1);
    localparam int FiW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int TaW  = (MAX_TRAIN_ROWS * FEATURE_COUNT > 1) ?
                          $clog2(MAX_TRAIN_ROWS * FEATURE_COUNT) : 1;
    localparam int DW   = $clog2(FEATURE_COUNT * 65025 + 1);
    localparam int CiW  = $clog2(CLASS_COUNT);
    localparam int KeyW = DW + LABEL_W + RiW;
    localparam int SqW  = 2 * FEAT_W;

    // memories
    logic [FEAT_W-1:0]      train_mem [MAX_TRAIN_ROWS * FEATURE_COUNT];
    logic [FEAT_W-1:0]      query_mem [FEATURE_COUNT];
    logic [LABEL_W-1:0]     label_mem [MAX_TRAIN_ROWS];
    logic [DW+LABEL_W-1:0]  dist_mem  [MAX_TRAIN_ROWS];

    // row bookkeeping
    logic [RcW-1:0]  row_count_reg;
    logic [TaW-1:0]  row_base_reg;
    logic [PosW-1:0] pos_reg;
    logic            overflow_reg;

    // zero fill
    logic [PosW-1:0] fill_pos_reg;
    logic [TaW-1:0]  fill_addr_reg;
    logic            fill_query_reg;

    // distance pipeline
    logic [RcW-1:0]  drow_reg;
    logic [FiW-1:0]  dfeat_reg;
    logic [TaW-1:0]  daddr_reg;
    logic            v1_reg, v2_reg;
    logic            last1_reg, last2_reg;
    logic [RiW-1:0]  row1_reg, row2_reg;
    logic [FEAT_W-1:0] q1_reg, t1_reg;
    logic [LABEL_W-1:0] lbl1_reg, lbl2_reg;
    logic [SqW-1:0]  sq2_reg;
    logic [DW-1:0]   acc_reg;

    // selection
    logic [RcW-1:0]  sidx_reg;
    logic            sv1_reg;
    logic [RiW-1:0]  sidx1_reg;
    logic [DW+LABEL_W-1:0] sdata1_reg;
    logic [KeyW-1:0] best_key_reg, last_key_reg;
    logic            have_best_reg, have_last_reg;
    logic [RcW-1:0]  picks_reg, pick_cnt_reg;

    // vote
    logic [K_W-1:0]  votes_reg [CLASS_COUNT];
    logic [CiW-1:0]  cls_reg, best_cls_reg;
    logic [K_W-1:0]  best_votes_reg;

    // output register
    logic               m_tvalid_reg;
    logic [LABEL_W-1:0] out_class_reg;
    logic               out_overflow_reg;

    logic            room;
    logic            pos_in;
    logic [PosW-1:0] pos_new;
    logic            op_train, op_query, op_clear;
    logic            t_we;
    logic [TaW-1:0]  t_waddr;
    logic [FEAT_W-1:0] t_wdata;
    logic            q_we;
    logic [FiW-1:0]  q_waddr;
    logic [FEAT_W-1:0] q_wdata;
    logic            commit;
    logic [LABEL_W-1:0] label_sat;
    logic            dist_issue;
    logic            scan_issue;
    logic [FEAT_W:0] diff;
    logic [FEAT_W-1:0] diff_abs;
    logic [DW-1:0]   acc_sum;
    logic [KeyW-1:0] scan_key;
    logic            scan_better;
    logic [LABEL_W-1:0] pick_label;

    assign op_train = in_op == OP_TRAIN;
    assign op_query = in_op == OP_QUERY;
    assign op_clear = in_op == OP_CLEAR;
    assign room     = row_count_reg < RcW'(MAX_TRAIN_ROWS);
    assign pos_in   = pos_reg < PosW'(FEATURE_COUNT);
    assign pos_new  = pos_in ? pos_reg + 1'b1 : pos_reg;
    assign commit   = cmd.take && op_train && in_last && room;
    assign label_sat = ({1'b0, in_label} >= (LABEL_W + 1)'(CLASS_COUNT)) ?
                       LABEL_W'(CLASS_COUNT - 1) : in_label;

    // store write ports: streamed feature or zero fill
    always_comb begin
        t_we    = 1'b0;
        t_waddr = fill_addr_reg;
        t_wdata = '0;
        q_we    = 1'b0;
        q_waddr = fill_pos_reg[FiW-1:0];
        q_wdata = '0;
        if (cmd.take) begin
            t_we    = op_train && room && pos_in;
            t_waddr = row_base_reg + TaW'(pos_reg);
            t_wdata = in_feature;
            q_we    = op_query && pos_in;
            q_waddr = pos_reg[FiW-1:0];
            q_wdata = in_feature;
        end else if (cmd.fill_step) begin
            t_we = !fill_query_reg;
            q_we = fill_query_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (t_we) begin
            train_mem[t_waddr] <= t_wdata;
        end
        t1_reg <= train_mem[daddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            query_mem[q_waddr] <= q_wdata;
        end
        q1_reg <= query_mem[dfeat_reg];
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            label_mem[row_count_reg[RiW-1:0]] <= label_sat;
        end
        lbl1_reg <= label_mem[drow_reg[RiW-1:0]];
    end

    // row bookkeeping and fill control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= '0;
            row_base_reg   <= '0;
            pos_reg        <= '0;
            overflow_reg   <= 1'b0;
            fill_pos_reg   <= '0;
            fill_addr_reg  <= '0;
            fill_query_reg <= 1'b0;
        end else if (cmd.take) begin
            if (op_clear) begin
                row_count_reg <= '0;
                row_base_reg  <= '0;
                pos_reg       <= '0;
                overflow_reg  <= 1'b0;
            end else if (op_train || op_query) begin
                pos_reg <= in_last ? '0 : pos_new;
                fill_pos_reg   <= pos_new;
                fill_addr_reg  <= row_base_reg + TaW'(pos_new);
                fill_query_reg <= op_query;
                if (op_train && in_last) begin
                    if (room) begin
                        row_count_reg <= row_count_reg + 1'b1;
                        row_base_reg  <= row_base_reg + TaW'(FEATURE_COUNT);
                    end else begin
                        overflow_reg <= 1'b1;
                    end
                end
            end
        end else if (cmd.fill_step) begin
            fill_pos_reg  <= fill_pos_reg + 1'b1;
            fill_addr_reg <= fill_addr_reg + 1'b1;
        end
    end

    // distance pipeline: read, square, accumulate
    assign dist_issue = cmd.dist_run && (drow_reg != row_count_reg);
    assign diff       = {1'b0, q1_reg} - {1'b0, t1_reg};
    assign diff_abs   = diff[FEAT_W] ? FEAT_W'(-diff) : diff[FEAT_W-1:0];
    assign acc_sum    = acc_reg + DW'(sq2_reg);

    always_ff @(posedge aclk) begin
        row1_reg  <= drow_reg[RiW-1:0];
        last1_reg <= dfeat_reg == FiW'(FEATURE_COUNT - 1);
        row2_reg  <= row1_reg;
        last2_reg <= last1_reg;
        lbl2_reg  <= lbl1_reg;
        sq2_reg   <= SqW'(diff_abs) * SqW'(diff_abs);
        if (v2_reg && last2_reg) begin
            dist_mem[row2_reg] <= {acc_sum, lbl2_reg};
        end
        sdata1_reg <= dist_mem[sidx_reg[RiW-1:0]];
        sidx1_reg  <= sidx_reg[RiW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drow_reg  <= '0;
            dfeat_reg <= '0;
            daddr_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            acc_reg   <= '0;
        end else begin
            v1_reg <= dist_issue;
            v2_reg <= v1_reg;
            if (cmd.dist_init) begin
                drow_reg  <= '0;
                dfeat_reg <= '0;
                daddr_reg <= '0;
                acc_reg   <= '0;
            end else begin
                if (dist_issue) begin
                    daddr_reg <= daddr_reg + 1'b1;
                    if (dfeat_reg == FiW'(FEATURE_COUNT - 1)) begin
                        dfeat_reg <= '0;
                        drow_reg  <= drow_reg + 1'b1;
                    end else begin
                        dfeat_reg <= dfeat_reg + 1'b1;
                    end
                end
                if (v2_reg) begin
                    acc_reg <= last2_reg ? '0 : acc_sum;
                end
            end
        end
    end

    // selection: each pick finds the smallest (distance, label, row) above the last pick
    assign scan_issue  = cmd.scan_run && (sidx_reg != row_count_reg);
    assign scan_key    = {sdata1_reg, sidx1_reg};
    assign scan_better = (!have_last_reg || scan_key > last_key_reg) &&
                         (!have_best_reg || scan_key < best_key_reg);
    assign pick_label  = best_key_reg[RiW +: LABEL_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sidx_reg      <= '0;
            sv1_reg       <= 1'b0;
            have_best_reg <= 1'b0;
            have_last_reg <= 1'b0;
            picks_reg     <= '0;
            pick_cnt_reg  <= '0;
        end else begin
            sv1_reg <= scan_issue;
            if (cmd.pick_init) begin
                have_last_reg <= 1'b0;
                pick_cnt_reg  <= '0;
                if (RcW > K_W || k_value <= K_W'(row_count_reg)) begin
                    picks_reg <= (RcW'(k_value) < row_count_reg) ?
                                 RcW'(k_value) : row_count_reg;
                end else begin
                    picks_reg <= row_count_reg;
                end
            end
            if (cmd.scan_init) begin
                sidx_reg      <= '0;
                have_best_reg <= 1'b0;
            end else if (scan_issue) begin
                sidx_reg <= sidx_reg + 1'b1;
            end
            if (sv1_reg && scan_better) begin
                have_best_reg <= 1'b1;
            end
            if (cmd.pick) begin
                have_last_reg <= 1'b1;
                pick_cnt_reg  <= pick_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sv1_reg && scan_better) begin
            best_key_reg <= scan_key;
        end
        if (cmd.pick) begin
            last_key_reg <= best_key_reg;
        end
    end

    // vote counters and arg-max sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                votes_reg[i] <= '0;
            end
            cls_reg        <= '0;
            best_cls_reg   <= '0;
            best_votes_reg <= '0;
        end else begin
            if (cmd.dist_init) begin
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    votes_reg[i] <= '0;
                end
            end else if (cmd.pick) begin
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    if (pick_label == LABEL_W'(i)) begin
                        votes_reg[i] <= votes_reg[i] + 1'b1;
                    end
                end
            end
            if (cmd.pick_init) begin
                cls_reg        <= '0;
                best_cls_reg   <= '0;
                best_votes_reg <= '0;
            end else if (cmd.argmax_run) begin
                cls_reg <= cls_reg + 1'b1;
                if (votes_reg[cls_reg] > best_votes_reg) begin
                    best_cls_reg   <= cls_reg;
                    best_votes_reg <= votes_reg[cls_reg];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_class_reg    <= LABEL_W'(best_cls_reg);
            out_overflow_reg <= overflow_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign out_class    = out_class_reg;
    assign out_overflow = out_overflow_reg;

    always_comb begin
        status             = '0;
        status.fill_req    = in_last && (pos_new < PosW'(FEATURE_COUNT)) &&
                             (op_query || (op_train && room));
        status.query_end   = in_last && op_query;
        status.fill_last   = fill_pos_reg == PosW'(FEATURE_COUNT - 1);
        status.fill_query  = fill_query_reg;
        status.dist_done   = (drow_reg == row_count_reg) && !v1_reg && !v2_reg;
        status.picks_zero  = (k_value == '0) || (row_count_reg == '0);
        status.scan_done   = (sidx_reg == row_count_reg) && !sv1_reg;
        status.pick_final  = (pick_cnt_reg + 1'b1) == picks_reg;
        status.argmax_done = cls_reg == CiW'(CLASS_COUNT - 1);
        status.out_free    = !m_tvalid_reg || m_tready;
    end

    // store never holds more rows than its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg <= RcW'(MAX_TRAIN_ROWS))
        else $error("row count beyond capacity");
    // a row commit advances the row count by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> row_count_reg == $past(row_count_reg) + 1'b1)
        else $error("row commit lost");
    // square stage only carries data read in the cycle before
    assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> $past(v1_reg))
        else $error("distance pipeline out of step");

endmodule

/* rtl/core/knn_classifier_core.sv */
// top level of the k-nearest-neighbor classifier
`timescale 1ns / 1ps
// usage:
//   s_ channel: one request per feature byte. s_tuser carries the operation (train feature,
//   query feature, clear store), s_tlast marks the last feature of a row, s_tdata holds the
//   feature value and, for a training row's last feature, its class label.
//   m_ channel: one result per query row, the predicted class and the overflow flag.
//   cfg_ channel: writes neighbor_count (reset 5); write only while the block is idle.
// flow:
//   a row ending short is zero padded, one position per cycle. a query then reads the
//   training store row by row, feature by feature, through its single read port, then makes
//   the neighbor picks (picks = min(neighbor_count, rows)), each a scan over all stored rows,
//   then an arg-max sweep over the class votes. one item is worked on at a time.
// reset: store empty, overflow flag clear, neighbor_count = 5, no result pending.
// stall: a finished result waits in the output register; training and other requests are
//   taken meanwhile, and the next query result waits until the register frees.
module knn_classifier_core #(
    parameter int MAX_TRAIN_ROWS = knn_pkg::MAX_TRAIN_ROWS_DEF,
    parameter int FEATURE_COUNT  = knn_pkg::FEATURE_COUNT_DEF,
    parameter int CLASS_COUNT    = knn_pkg::CLASS_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] feature_value, [11:8] class_label, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        s_tlast,   // row_last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] predicted_class, [4] store_overflowed, [7:5] zero
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // neighbor_count
);
    import knn_pkg::*;

    knn_cmd_t           cmd;
    knn_status_t        status;
    logic [K_W-1:0]     k_reg;
    logic [LABEL_W-1:0] out_class;
    logic               out_overflow;

    // neighbor count register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
        end else if (cfg_valid) begin
            k_reg <= cfg_data;
        end
    end

    knn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    knn_dpath #(
        .MAX_TRAIN_ROWS (MAX_TRAIN_ROWS),
        .FEATURE_COUNT  (FEATURE_COUNT),
        .CLASS_COUNT    (CLASS_COUNT)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_op        (s_tuser),
        .in_feature   (s_tdata[7:0]),
        .in_label     (s_tdata[11:8]),
        .in_last      (s_tlast),
        .k_value      (k_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_class    (out_class),
        .out_overflow (out_overflow)
    );

    assign m_tdata = {3'b000, out_overflow, out_class};

endmodule

/* test/knn_classifier_core_tb.sv */
// self-checking testbench for the knn classifier core: feature stream in, class results out
`timescale 1ns / 1ps
module knn_classifier_core_tb;
    import knn_pkg::*;

    localparam int ROWS  = MAX_TRAIN_ROWS_DEF;
    localparam int FEATS = FEATURE_COUNT_DEF;
    localparam int NCLS  = CLASS_COUNT_DEF;

    typedef struct packed {
        knn_op_t     op;
        logic [7:0]  val;
        logic [3:0]  lab;
        logic        last;
    } feat_req_t;

    typedef struct packed {
        logic [3:0] cls;
        logic       ovf;
    } vote_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] feature_value, [11:8] class_label, [15:12] zero
    logic [1:0]  s_tuser = '0;   // [1:0] operation
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;        // [3:0] predicted_class, [4] store_overflowed
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd5;

    knn_classifier_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // shadow state of the classifier
    logic [7:0] train_feat [0:ROWS-1][0:FEATS-1];
    logic [3:0] train_lab [0:ROWS-1];
    logic [7:0] query_feat [0:FEATS-1];
    int         rows_held = 0;
    int         feat_pos = 0;
    bit         ovf_flag = 0;
    int         nbr_count = 5;

    feat_req_t  feat_q[$];
    vote_t      vote_q[$];
    feat_req_t  cur, nxt;
    bit         in_flight = 0;
    bit         quiet = 0;
    int         gap = 0;
    int         stall = 0;
    int         hold_cnt = 0;
    bit         hold_go = 0;
    bit         hold_used = 0;
    int         errors = 0;
    int         rand_items = 0;

    function automatic logic [3:0] nearest_vote();
        longint row_dist [0:ROWS-1];
        bit     taken [0:ROWS-1];
        int     votes [0:NCLS-1];
        longint s;
        int     d, picks, best, c;
        bit     have;
        for (int i = 0; i < NCLS; i++) votes[i] = 0;
        for (int r = 0; r < rows_held; r++) begin
            s = 0;
            for (int f = 0; f < FEATS; f++) begin
                d = int'(query_feat[f]) - int'(train_feat[r][f]);
                s += d * d;
            end
            row_dist[r] = s;
            taken[r] = 0;
        end
        picks = nbr_count < rows_held ? nbr_count : rows_held;
        for (int p = 0; p < picks; p++) begin
            have = 0;
            best = 0;
            for (int r = 0; r < rows_held; r++) begin
                if (taken[r]) continue;
                if (!have || row_dist[r] < row_dist[best] ||
                    (row_dist[r] == row_dist[best] && train_lab[r] < train_lab[best])) begin
                    best = r;
                    have = 1;
                end
            end
            taken[best] = 1;
            votes[train_lab[best]]++;
        end
        c = 0;
        for (int i = 1; i < NCLS; i++) if (votes[i] > votes[c]) c = i;
        return c[3:0];
    endfunction

    // advance the shadow state by one accepted request
    task automatic absorb_request(feat_req_t r);
        vote_t v;
        case (r.op)
            OP_CLEAR: begin
                rows_held = 0;
                ovf_flag = 0;
                feat_pos = 0;
            end
            OP_TRAIN: begin
                if (rows_held < ROWS && feat_pos < FEATS) train_feat[rows_held][feat_pos] = r.val;
                if (feat_pos < FEATS) feat_pos++;
                if (r.last) begin
                    if (rows_held < ROWS) begin
                        for (int p = feat_pos; p < FEATS; p++) train_feat[rows_held][p] = 0;
                        train_lab[rows_held] = r.lab >= NCLS ? 4'(NCLS - 1) : r.lab;
                        rows_held++;
                    end else begin
                        ovf_flag = 1;
                    end
                    feat_pos = 0;
                end
            end
            OP_QUERY: begin
                if (feat_pos < FEATS) query_feat[feat_pos] = r.val;
                if (feat_pos < FEATS) feat_pos++;
                if (r.last) begin
                    for (int p = feat_pos; p < FEATS; p++) query_feat[p] = 0;
                    feat_pos = 0;
                    v.cls = nearest_vote();
                    v.ovf = ovf_flag;
                    vote_q.insert(vote_q.size(), v);
                end
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_request(cur);
                in_flight = 0;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current request
            end else if (gap != 0) begin
                gap <= gap - 1;
                s_tvalid <= 0;
            end else if (feat_q.size() != 0) begin
                nxt = feat_q.pop_front();
                in_flight = 1;
                cur <= nxt;
                s_tdata <= {4'b0, nxt.lab, nxt.val};
                s_tuser <= nxt.op;
                s_tlast <= nxt.last;
                s_tvalid <= 1;
                if (!quiet && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 14);
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // long receiver hold-off, runs once
    always @(posedge aclk) begin
        if (hold_go && !hold_used && hold_cnt == 0) begin
            hold_cnt <= 6000;
            hold_used <= 1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (vote_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", m_tdata);
                end else if (vote_q[0].cls !== m_tdata[3:0] || vote_q[0].ovf !== m_tdata[4]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected class %0d ovf %0d, got class %0d ovf %0d",
                                 vote_q[0].cls, vote_q[0].ovf, m_tdata[3:0], m_tdata[4]);
                    void'(vote_q.pop_front());
                end else begin
                    void'(vote_q.pop_front());
                end
            end
            if (hold_cnt != 0) begin
                m_tready <= 0;
            end else if (stall != 0) begin
                stall <= stall - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (!quiet && $urandom_range(0, 7) == 0) stall <= $urandom_range(1, 14);
            end
        end
    end

    task automatic push_req(knn_op_t op, logic [7:0] val, logic [3:0] lab, logic last);
        feat_req_t r;
        r.op = op;
        r.val = val;
        r.lab = lab;
        r.last = last;
        feat_q.insert(feat_q.size(), r);
        rand_items++;
    endtask

    function automatic logic [7:0] pick_val();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic train_row(int len, logic [3:0] lab);
        for (int i = 0; i < len; i++)
            push_req(OP_TRAIN, pick_val(), i == len - 1 ? lab : 4'($urandom), i == len - 1);
    endtask

    // a query row, optionally with its second feature sent as a training feature
    task automatic query_row(int len, bit mixed);
        for (int i = 0; i < len; i++)
            push_req(mixed && i == 1 ? OP_TRAIN : OP_QUERY, pick_val(), 4'($urandom),
                     i == len - 1);
    endtask

    task automatic write_k(logic [7:0] k);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= k;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        nbr_count = k;
    endtask

    // wait until every request is taken and every result is in, then let the block go idle
    task automatic settle();
        while (feat_q.size() != 0 || in_flight || vote_q.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        repeat (2) @(posedge aclk);

        // empty store votes for class 0; short query is zero padded
        query_row(1, 0);
        push_req(OP_CLEAR, 8'hff, 4'hf, 1);
        // label above range saturates, extremes of the feature value
        train_row(1, 4'd15);
        push_req(OP_TRAIN, 8'd0, 4'd0, 0);
        push_req(OP_UNUSED, 8'haa, 4'h5, 1);   // ignored mid row
        push_req(OP_TRAIN, 8'd0, 4'd3, 1);
        // long row: features past the end are dropped
        for (int i = 0; i < FEATS + 3; i++)
            push_req(OP_TRAIN, 8'($urandom), 4'd7, i == FEATS + 2);
        query_row(2, 0);
        query_row(3, 1);                       // mixed operations in one row
        settle();

        // k = 1, distance tie broken toward smaller label, plus receiver pressure
        write_k(8'd1);
        push_req(OP_CLEAR, 8'd0, 4'd0, 0);
        push_req(OP_TRAIN, 8'd9, 4'd6, 1);
        push_req(OP_TRAIN, 8'd9, 4'd2, 1);
        hold_go = 1;
        for (int i = 0; i < 4; i++) begin
            push_req(OP_QUERY, 8'd9, 4'd0, 0);
            push_req(OP_QUERY, 8'd1, 4'd0, 1);
        end
        settle();

        // store full, overflow row dropped, k at its top
        write_k(8'd255);
        push_req(OP_CLEAR, 8'd0, 4'd0, 0);
        for (int i = 0; i < ROWS; i++) train_row(1, 4'($urandom_range(0, 9)));
        train_row(2, 4'd1);
        query_row(1, 0);
        settle();

        // k of zero: nobody votes; clear drops the overflow flag
        write_k(8'd0);
        push_req(OP_CLEAR, 8'd0, 4'd0, 0);
        train_row(1, 4'd4);
        query_row(1, 0);
        settle();

        rand_items = 0;
        while (rand_items < 680) begin
            if (rand_items > 580) quiet = 1;
            case ($urandom_range(0, 4))
                0: write_k(8'd1);
                1: write_k(8'd255);
                2: write_k(8'($urandom_range(1, 4)));
                default: write_k(8'($urandom_range(1, 255)));
            endcase
            push_req(OP_CLEAR, 8'($urandom), 4'($urandom), 1'($urandom));
            for (int r = $urandom_range(1, 8); r > 0; r--) begin
                train_row($urandom_range(1, 6), 4'($urandom));
                if ($urandom_range(0, 5) == 0)
                    push_req(OP_UNUSED, 8'($urandom), 4'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 6) == 0) begin
                // broken row cut short by a clear, then a fresh row
                push_req(OP_TRAIN, pick_val(), 4'($urandom), 0);
                push_req(OP_CLEAR, 8'($urandom), 4'($urandom), 0);
                train_row($urandom_range(1, 4), 4'($urandom));
            end
            for (int q = $urandom_range(1, 4); q > 0; q--)
                query_row($urandom_range(2, 8), $urandom_range(0, 4) == 0);
            settle();
        end

        settle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
